// File: rtl/core/point_cloud_quaternion_rotate_top_assert.svh
// Assertion macros shared by the quaternion rotate RTL.
`ifndef POINT_CLOUD_QUATERNION_ROTATE_TOP_ASSERT_SVH
`define POINT_CLOUD_QUATERNION_ROTATE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define PCQR_ASSERT_SAME(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("pcqr: same-cycle check failed");
`define PCQR_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("pcqr: next-cycle check failed");
`else
`define PCQR_ASSERT_SAME(lbl, ant, con)
`define PCQR_ASSERT_NEXT(lbl, ant, con)
`endif

`endif

// File: rtl/core/pcqr_pkg.sv
// Package: constants, types and codes of the quaternion point rotator.
`timescale 1ns / 1ps
`default_nettype none
package pcqr_pkg;
  localparam int DEF_COORD_WIDTH = 24;
  localparam int DEF_QUAT_WIDTH  = 16;
  localparam int NORM_W = 17;
  localparam int PQ_W   = 32;
  localparam int MAT_W  = 34;
  localparam int QUO_W  = 33;
  localparam int RAD_W  = 34;
  localparam int ROOT_W = 17;
  localparam int SQ_W   = 21;
  localparam int CNT_W  = 6;
  localparam int NPROD  = 10;
  localparam int NMAT   = 9;
  localparam int RSHIFT = 30;
  localparam logic [CNT_W-1:0] DIV_LAST  = 6'd32;
  localparam logic [CNT_W-1:0] SQRT_LAST = 6'd16;
  localparam logic [CNT_W-1:0] PROD_LAST = 6'd9;
  localparam logic signed [NORM_W-1:0] ONE_Q   = 17'sd32768;
  localparam logic signed [MAT_W-1:0]  MAT_ONE = 34'sd1073741824;

  typedef enum logic [1:0] {
    REG_ROT_X = 2'd0,
    REG_ROT_Y = 2'd1,
    REG_ROT_Z = 2'd2,
    REG_ROT_W = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    N_IDLE, N_SUM, N_LOAD, N_DIV, N_SQRT, N_STORE, N_PROD, N_MAT
  } norm_state_t;

  typedef struct packed {
    logic                            ready;
    logic [NMAT-1:0][MAT_W-1:0]      ent;
  } rot_mat_t;
endpackage
`default_nettype wire

// File: rtl/core/pcqr_norm.sv
// Quaternion normalizer: sequential divide and square root, builds the rotation matrix.
`timescale 1ns / 1ps
`default_nettype none
`include "point_cloud_quaternion_rotate_top_assert.svh"
module pcqr_norm #(
  parameter int QUAT_WIDTH = pcqr_pkg::DEF_QUAT_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_addr,
  input  wire logic [QUAT_WIDTH-1:0]  cfg_wdata,
  output pcqr_pkg::rot_mat_t          mat
);
  localparam int SQR_W = 2 * QUAT_WIDTH;
  localparam int SUM_W = SQR_W + 1;
  localparam int REM_W = SUM_W + 1;

  pcqr_pkg::norm_state_t state_r, state_nxt;
  logic signed [QUAT_WIDTH-1:0] rot_x_r, rot_y_r, rot_z_r, rot_w_r;
  logic [pcqr_pkg::CNT_W-1:0]   cnt_r;
  logic [1:0]                   comp_r;
  logic [SUM_W-1:0]             sum_r;
  logic [REM_W-1:0]             rem_r;
  logic [pcqr_pkg::QUO_W-1:0]   quo_r;
  logic [pcqr_pkg::RAD_W-1:0]   rad_r;
  logic [pcqr_pkg::SQ_W-1:0]    sqr_r;
  logic [pcqr_pkg::ROOT_W-1:0]  root_r;
  logic signed [pcqr_pkg::NORM_W-1:0] nx_r, ny_r, nz_r, nw_r;
  logic signed [pcqr_pkg::PQ_W-1:0]   prod_r [pcqr_pkg::NPROD];
  logic [pcqr_pkg::NMAT-1:0][pcqr_pkg::MAT_W-1:0] ent_r, ent_val;

  logic signed [QUAT_WIDTH-1:0] comp_val;
  logic signed [SQR_W-1:0]      comp_sq;
  logic [SUM_W-1:0]             sq_ext, sum_acc;
  logic [REM_W-1:0]             shifted, diff;
  logic                         div_ge;
  logic [pcqr_pkg::SQ_W-1:0]    sq_sh, trial;
  logic                         sq_ge;
  logic [pcqr_pkg::ROOT_W:0]    half;
  logic signed [pcqr_pkg::NORM_W-1:0] nval, nmag, pa, pb;
  logic signed [2*pcqr_pkg::NORM_W-1:0] prod_full;
  logic signed [pcqr_pkg::MAT_W-1:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;

  always_comb begin
    case (pcqr_pkg::reg_idx_t'(comp_r))
      pcqr_pkg::REG_ROT_X: comp_val = rot_x_r;
      pcqr_pkg::REG_ROT_Y: comp_val = rot_y_r;
      pcqr_pkg::REG_ROT_Z: comp_val = rot_z_r;
      default:             comp_val = rot_w_r;
    endcase
    comp_sq = comp_val * comp_val;
    sq_ext  = {1'b0, comp_sq};
    sum_acc = sum_r + sq_ext;
    shifted = (cnt_r == '0) ? rem_r : {rem_r[REM_W-2:0], 1'b0};
    div_ge  = shifted >= {1'b0, sum_r};
    diff    = shifted - {1'b0, sum_r};
    sq_sh   = {sqr_r[pcqr_pkg::SQ_W-3:0], rad_r[pcqr_pkg::RAD_W-1:pcqr_pkg::RAD_W-2]};
    trial   = {2'b00, root_r, 2'b01};
    sq_ge   = sq_sh >= trial;
    half    = {1'b0, root_r} + (pcqr_pkg::ROOT_W + 1)'(1);
    nmag    = $signed(half[pcqr_pkg::ROOT_W:1]);
    nval    = comp_val[QUAT_WIDTH-1] ? -nmag : nmag;
    case (cnt_r[3:0])
      4'd0:    begin pa = nx_r; pb = nx_r; end
      4'd1:    begin pa = ny_r; pb = ny_r; end
      4'd2:    begin pa = nz_r; pb = nz_r; end
      4'd3:    begin pa = nw_r; pb = nw_r; end
      4'd4:    begin pa = nx_r; pb = ny_r; end
      4'd5:    begin pa = nx_r; pb = nz_r; end
      4'd6:    begin pa = ny_r; pb = nz_r; end
      4'd7:    begin pa = nw_r; pb = nx_r; end
      4'd8:    begin pa = nw_r; pb = ny_r; end
      default: begin pa = nw_r; pb = nz_r; end
    endcase
    prod_full = pa * pb;
    xx = pcqr_pkg::MAT_W'(prod_r[0]);
    yy = pcqr_pkg::MAT_W'(prod_r[1]);
    zz = pcqr_pkg::MAT_W'(prod_r[2]);
    ww = pcqr_pkg::MAT_W'(prod_r[3]);
    xy = pcqr_pkg::MAT_W'(prod_r[4]);
    xz = pcqr_pkg::MAT_W'(prod_r[5]);
    yz = pcqr_pkg::MAT_W'(prod_r[6]);
    wx = pcqr_pkg::MAT_W'(prod_r[7]);
    wy = pcqr_pkg::MAT_W'(prod_r[8]);
    wz = pcqr_pkg::MAT_W'(prod_r[9]);
    ent_val[0] = ww + xx - yy - zz;
    ent_val[1] = (xy - wz) <<< 1;
    ent_val[2] = (xz + wy) <<< 1;
    ent_val[3] = (xy + wz) <<< 1;
    ent_val[4] = ww - xx + yy - zz;
    ent_val[5] = (yz - wx) <<< 1;
    ent_val[6] = (xz - wy) <<< 1;
    ent_val[7] = (yz + wx) <<< 1;
    ent_val[8] = ww - xx - yy + zz;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pcqr_pkg::N_IDLE:  state_nxt = pcqr_pkg::N_IDLE;
      pcqr_pkg::N_SUM: begin
        if (comp_r == 2'd3) begin
          state_nxt = (sum_acc == '0) ? pcqr_pkg::N_PROD : pcqr_pkg::N_LOAD;
        end
      end
      pcqr_pkg::N_LOAD:  state_nxt = pcqr_pkg::N_DIV;
      pcqr_pkg::N_DIV: begin
        if (cnt_r == pcqr_pkg::DIV_LAST) state_nxt = pcqr_pkg::N_SQRT;
      end
      pcqr_pkg::N_SQRT: begin
        if (cnt_r == pcqr_pkg::SQRT_LAST) state_nxt = pcqr_pkg::N_STORE;
      end
      pcqr_pkg::N_STORE: begin
        state_nxt = (comp_r == 2'd3) ? pcqr_pkg::N_PROD : pcqr_pkg::N_LOAD;
      end
      pcqr_pkg::N_PROD: begin
        if (cnt_r == pcqr_pkg::PROD_LAST) state_nxt = pcqr_pkg::N_MAT;
      end
      pcqr_pkg::N_MAT:   state_nxt = pcqr_pkg::N_IDLE;
      default:           state_nxt = pcqr_pkg::N_IDLE;
    endcase
    if (cfg_we) state_nxt = pcqr_pkg::N_SUM;
    mat.ready = (state_r == pcqr_pkg::N_IDLE);
    mat.ent   = ent_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcqr_pkg::N_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_x_r <= '0;
      rot_y_r <= '0;
      rot_z_r <= '0;
      rot_w_r <= QUAT_WIDTH'(16384);
      cnt_r   <= '0;
      comp_r  <= '0;
      for (int i = 0; i < pcqr_pkg::NMAT; i++) begin
        ent_r[i] <= (i % 4 == 0) ? pcqr_pkg::MAT_ONE : '0;
      end
    end else if (cfg_we) begin
      case (pcqr_pkg::reg_idx_t'(cfg_addr))
        pcqr_pkg::REG_ROT_X: rot_x_r <= cfg_wdata;
        pcqr_pkg::REG_ROT_Y: rot_y_r <= cfg_wdata;
        pcqr_pkg::REG_ROT_Z: rot_z_r <= cfg_wdata;
        default:             rot_w_r <= cfg_wdata;
      endcase
      comp_r <= '0;
      cnt_r  <= '0;
      sum_r  <= '0;
    end else begin
      case (state_r)
        pcqr_pkg::N_SUM: begin
          sum_r  <= sum_acc;
          comp_r <= comp_r + 2'd1;
          cnt_r  <= '0;
          if (comp_r == 2'd3 && sum_acc == '0) begin
            nx_r <= '0;
            ny_r <= '0;
            nz_r <= '0;
            nw_r <= pcqr_pkg::ONE_Q;
          end
        end
        pcqr_pkg::N_LOAD: begin
          rem_r <= {1'b0, sq_ext};
          quo_r <= '0;
          cnt_r <= '0;
        end
        pcqr_pkg::N_DIV: begin
          rem_r <= div_ge ? diff : shifted;
          quo_r <= {quo_r[pcqr_pkg::QUO_W-2:0], div_ge};
          if (cnt_r == pcqr_pkg::DIV_LAST) begin
            cnt_r  <= '0;
            rad_r  <= {1'b0, quo_r[pcqr_pkg::QUO_W-2:0], div_ge};
            sqr_r  <= '0;
            root_r <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        pcqr_pkg::N_SQRT: begin
          sqr_r  <= sq_ge ? sq_sh - trial : sq_sh;
          root_r <= {root_r[pcqr_pkg::ROOT_W-2:0], sq_ge};
          rad_r  <= rad_r << 2;
          cnt_r  <= cnt_r + 1'b1;
        end
        pcqr_pkg::N_STORE: begin
          case (pcqr_pkg::reg_idx_t'(comp_r))
            pcqr_pkg::REG_ROT_X: nx_r <= nval;
            pcqr_pkg::REG_ROT_Y: ny_r <= nval;
            pcqr_pkg::REG_ROT_Z: nz_r <= nval;
            default:             nw_r <= nval;
          endcase
          comp_r <= comp_r + 2'd1;
          cnt_r  <= '0;
        end
        pcqr_pkg::N_PROD: begin
          prod_r[cnt_r[3:0]] <= pcqr_pkg::PQ_W'(prod_full);
          cnt_r <= cnt_r + 1'b1;
        end
        pcqr_pkg::N_MAT: begin
          ent_r <= ent_val;
          cnt_r <= '0;
        end
        default: begin
          cnt_r <= '0;
        end
      endcase
    end
  end

  `PCQR_ASSERT_NEXT(a_cfg_restart, cfg_we, state_r == pcqr_pkg::N_SUM)
  `PCQR_ASSERT_NEXT(a_div_to_sqrt, state_r == pcqr_pkg::N_DIV && cnt_r == pcqr_pkg::DIV_LAST && !cfg_we, state_r == pcqr_pkg::N_SQRT)
  `PCQR_ASSERT_NEXT(a_idle_holds, state_r == pcqr_pkg::N_IDLE && !cfg_we, state_r == pcqr_pkg::N_IDLE)
  `PCQR_ASSERT_SAME(a_sqrt_cnt, state_r == pcqr_pkg::N_SQRT, cnt_r <= pcqr_pkg::SQRT_LAST)
endmodule
`default_nettype wire

// File: rtl/core/pcqr_rot_pipe.sv
// Rotation pipeline: matrix products, row sums, round and saturate.
`timescale 1ns / 1ps
`default_nettype none
`include "point_cloud_quaternion_rotate_top_assert.svh"
module pcqr_rot_pipe #(
  parameter int COORD_WIDTH = pcqr_pkg::DEF_COORD_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pcqr_pkg::rot_mat_t            mat,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] pos_x,
  input  wire logic signed [COORD_WIDTH-1:0] pos_y,
  input  wire logic signed [COORD_WIDTH-1:0] pos_z,
  input  wire logic [7:0]                    red,
  input  wire logic [7:0]                    green,
  input  wire logic [7:0]                    blue,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0]      out_x,
  output logic signed [COORD_WIDTH-1:0]      out_y,
  output logic signed [COORD_WIDTH-1:0]      out_z,
  output logic [7:0]                         out_red,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_blue
);
  localparam int MUL_W = pcqr_pkg::MAT_W + COORD_WIDTH;
  localparam int ACC_W = MUL_W + 2;

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;
  logic signed [MUL_W-1:0] p1_r [pcqr_pkg::NMAT];
  logic signed [ACC_W-1:0] acc2_r [3];
  logic [7:0] r1_r, g1_r, b1_r, r2_r, g2_r, b2_r, r3_r, g3_r, b3_r;
  logic signed [COORD_WIDTH-1:0] res3_r [3];
  logic signed [COORD_WIDTH-1:0] pos [3];
  logic signed [MUL_W-1:0] p_nxt [pcqr_pkg::NMAT];
  logic signed [ACC_W-1:0] acc_nxt [3];
  logic [ACC_W-1:0] mag [3];
  logic [ACC_W-1:0] rq [3];
  logic [ACC_W-1:0] lim;
  logic signed [COORD_WIDTH-1:0] res_nxt [3];

  always_comb begin
    en3 = !v3_r || out_ready;
    en2 = !v2_r || en3;
    en1 = !v1_r || en2;
    in_ready = en1;
    pos[0] = pos_x;
    pos[1] = pos_y;
    pos[2] = pos_z;
    for (int i = 0; i < pcqr_pkg::NMAT; i++) begin
      p_nxt[i] = $signed(mat.ent[i]) * pos[i % 3];
    end
    lim = ACC_W'(1) << (COORD_WIDTH - 1);
    for (int r = 0; r < 3; r++) begin
      acc_nxt[r] = ACC_W'(p1_r[3*r]) + ACC_W'(p1_r[3*r+1]) + ACC_W'(p1_r[3*r+2]);
      mag[r] = acc2_r[r][ACC_W-1] ? ACC_W'(-acc2_r[r]) : ACC_W'(acc2_r[r]);
      rq[r]  = (mag[r] + (ACC_W'(1) << (pcqr_pkg::RSHIFT - 1))) >> pcqr_pkg::RSHIFT;
      if (acc2_r[r][ACC_W-1]) begin
        res_nxt[r] = COORD_WIDTH'(-((rq[r] > lim) ? lim : rq[r]));
      end else begin
        res_nxt[r] = COORD_WIDTH'((rq[r] > lim - 1'b1) ? lim - 1'b1 : rq[r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < pcqr_pkg::NMAT; i++) p1_r[i] <= p_nxt[i];
      r1_r <= red;
      g1_r <= green;
      b1_r <= blue;
    end
    if (en2) begin
      for (int r = 0; r < 3; r++) acc2_r[r] <= acc_nxt[r];
      r2_r <= r1_r;
      g2_r <= g1_r;
      b2_r <= b1_r;
    end
    if (en3) begin
      for (int r = 0; r < 3; r++) res3_r[r] <= res_nxt[r];
      r3_r <= r2_r;
      g3_r <= g2_r;
      b3_r <= b2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_x     = res3_r[0];
  assign out_y     = res3_r[1];
  assign out_z     = res3_r[2];
  assign out_red   = r3_r;
  assign out_green = g3_r;
  assign out_blue  = b3_r;

  `PCQR_ASSERT_NEXT(a_load_s1, in_valid && in_ready, v1_r)
  `PCQR_ASSERT_NEXT(a_hold_s1, v1_r && !en2, v1_r)
  `PCQR_ASSERT_NEXT(a_move_s3, v2_r && en3, v3_r)
endmodule
`default_nettype wire

// File: rtl/core/point_cloud_quaternion_rotate_top.sv
// Top level of the quaternion point rotator.
// Use: write rot_x, rot_y, rot_z, rot_w (index 0..3) through cfg_we/cfg_addr/cfg_wdata
// while no point is in flight. Each write restarts normalization of the quaternion
// (divide by the root of the sum of squares, one bit a cycle), which holds in_tready
// low until it ends after the last write; a zero quaternion gives the identity.
// Points enter on in_t* and leave on out_t*, one beat per point, color copied.
// Throughput: one point per cycle while out_tready is high and no normalization runs,
// set by the three-stage multiply, sum and round pipeline.
// When out_tready is low, results hold in the output stage; empty stages still
// fill, so in_tready drops only once every stage holds a beat.
// Reset: quaternion returns to (0,0,0,16384), i.e. identity, ready at once;
// the pipeline empties.
`timescale 1ns / 1ps
`default_nettype none
module point_cloud_quaternion_rotate_top #(
  parameter int COORD_WIDTH = pcqr_pkg::DEF_COORD_WIDTH,
  parameter int QUAT_WIDTH  = pcqr_pkg::DEF_QUAT_WIDTH,
  localparam int TD_W = ((3 * COORD_WIDTH + 24 + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // pos_x, pos_y, pos_z, red, green, blue
  input  wire logic [TD_W-1:0]       in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // out_x, out_y, out_z, out_red, out_green, out_blue
  output logic [TD_W-1:0]            out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_addr,
  input  wire logic [QUAT_WIDTH-1:0] cfg_wdata
);
  localparam int CW = COORD_WIDTH;

  pcqr_pkg::rot_mat_t mat;
  logic pipe_ready;
  logic signed [CW-1:0] ox, oy, oz;
  logic [7:0] ored, ogreen, oblue;

  pcqr_norm #(.QUAT_WIDTH(QUAT_WIDTH)) u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .mat       (mat)
  );

  pcqr_rot_pipe #(.COORD_WIDTH(COORD_WIDTH)) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .mat       (mat),
    .in_valid  (in_tvalid && mat.ready),
    .in_ready  (pipe_ready),
    .pos_x     ($signed(in_tdata[CW-1:0])),
    .pos_y     ($signed(in_tdata[2*CW-1:CW])),
    .pos_z     ($signed(in_tdata[3*CW-1:2*CW])),
    .red       (in_tdata[3*CW+7:3*CW]),
    .green     (in_tdata[3*CW+15:3*CW+8]),
    .blue      (in_tdata[3*CW+23:3*CW+16]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (ox),
    .out_y     (oy),
    .out_z     (oz),
    .out_red   (ored),
    .out_green (ogreen),
    .out_blue  (oblue)
  );

  assign in_tready = pipe_ready && mat.ready;
  assign out_tdata = TD_W'({oblue, ogreen, ored, oz, oy, ox});
endmodule
`default_nettype wire
